>>> rtl/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

  // Field widths of the stream items.
  localparam int unsigned LenW  = 16;
  localparam int unsigned FldW  = 16;
  localparam int unsigned RowW  = 24;
  localparam int unsigned CfgW  = 24;
  localparam int unsigned CfgIdxW = 2;

  // Characters that steer the tokenizer.
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChHash  = 8'h23;

  // Event codes of a result.
  localparam logic [1:0] EvData   = 2'd0;
  localparam logic [1:0] EvField  = 2'd1;
  localparam logic [1:0] EvRecord = 2'd2;
  localparam logic [1:0] EvError  = 2'd3;

  // Error codes.
  localparam logic [1:0] ErrLength = 2'd0;
  localparam logic [1:0] ErrFields = 2'd1;
  localparam logic [1:0] ErrRows   = 2'd2;
  localparam logic [1:0] ErrQuote  = 2'd3;

  // Item kinds.
  localparam logic KindByte = 1'b0;
  localparam logic KindEod  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMaxFieldLen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxFields   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxRows     = 2'd2;

  // Configuration reset values.
  localparam logic [LenW-1:0] MaxFieldLenRst = 16'd4096;
  localparam logic [FldW-1:0] MaxFieldsRst   = 16'd256;
  localparam logic [RowW-1:0] MaxRowsRst     = 24'd65535;

  // Byte classes produced by the front end.
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_QUOTE,
    CLS_COMMA,
    CLS_CR,
    CLS_LF,
    CLS_HASH
  } cls_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      event_res;
    logic [7:0]      data_byte;
    logic [1:0]      error_code;
    logic [FldW-1:0] field_number;
    logic [RowW-1:0] row_number;
  } out_item_t;

  // Classified item carried through the queue.
  typedef struct packed {
    logic       kind;
    cls_e       cls;
    logic [7:0] byte_in;
  } tok_t;

  // Limits handed to the parser.
  typedef struct packed {
    logic [LenW-1:0] max_field_len;
    logic [FldW-1:0] max_fields;
    logic [RowW-1:0] row_limit;
  } limits_t;

endpackage

`default_nettype wire

>>> rtl/cst_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cst_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cst_pkg::in_item_t in_data_i,
  output logic               tok_valid_o,
  output cst_pkg::tok_t      tok_o,
  input  wire logic          tok_pop_i
);
  import cst_pkg::*;

  tok_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  tok_t       tok_new;
  logic       push;
  logic       pop;

  // Classify the incoming byte.
  always_comb begin
    tok_new.kind    = in_data_i.kind;
    tok_new.byte_in = in_data_i.byte_in;
    unique case (in_data_i.byte_in)
      ChQuote: tok_new.cls = CLS_QUOTE;
      ChComma: tok_new.cls = CLS_COMMA;
      ChCr:    tok_new.cls = CLS_CR;
      ChLf:    tok_new.cls = CLS_LF;
      ChHash:  tok_new.cls = CLS_HASH;
      default: tok_new.cls = CLS_OTHER;
    endcase
  end

  // Two-entry queue toward the parser.
  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign tok_valid_o = (count_q != 2'd0);
  assign pop         = tok_pop_i && tok_valid_o;
  assign tok_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= tok_new;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cst_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cst_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cst_pkg::limits_t limits_i,
  input  wire logic             tok_valid_i,
  input  wire cst_pkg::tok_t    tok_i,
  output logic                  tok_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output cst_pkg::out_item_t    out_data_o
);
  import cst_pkg::*;

  logic            iq_q, iq_d;
  logic            qp_q, qp_d;
  logic            crp_q, crp_d;
  logic            cmt_q, cmt_d;
  logic            ars_q, ars_d;
  logic            err_q, err_d;
  logic [LenW-1:0] flen_q, flen_d;
  logic [FldW-1:0] fcnt_q, fcnt_d;
  logic [RowW-1:0] rcnt_q, rcnt_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q;

  logic       go;
  logic       emit;
  logic [1:0] ev;
  logic [7:0] data;
  logic [1:0] code;
  logic       do_unq, do_chr, do_fld, do_rec, do_clear;
  logic [7:0] chr;

  // The parser takes a token whenever the output slot is free or drains.
  assign go        = tok_valid_i && (!out_valid_q || out_ready_i);
  assign tok_pop_o = go;

  // Parse one token.
  always_comb begin
    iq_d  = iq_q;
    qp_d  = qp_q;
    crp_d = crp_q;
    cmt_d = cmt_q;
    ars_d = ars_q;
    err_d = err_q;
    flen_d = flen_q;
    fcnt_d = fcnt_q;
    rcnt_d = rcnt_q;
    emit = 1'b0;
    ev   = EvData;
    data = 8'd0;
    code = ErrLength;
    do_unq = 1'b0;
    do_chr = 1'b0;
    do_fld = 1'b0;
    do_rec = 1'b0;
    do_clear = 1'b0;
    chr = tok_i.byte_in;

    if (tok_i.kind == KindEod) begin
      // End of document: close out, then return to the initial state.
      do_clear = 1'b1;
      if (!err_q) begin
        if (iq_q && !qp_q) begin
          emit  = 1'b1;
          ev    = EvError;
          code  = ErrQuote;
        end else if (!ars_q || flen_q != '0 || fcnt_q != '0) begin
          do_rec = 1'b1;
        end
      end
    end else if (!err_q) begin
      if (qp_q) begin
        // Byte after a quote inside a quoted field.
        qp_d = 1'b0;
        if (tok_i.cls == CLS_QUOTE) begin
          do_chr = 1'b1;
        end else begin
          iq_d   = 1'b0;
          do_unq = 1'b1;
        end
      end else if (crp_q && tok_i.cls == CLS_LF) begin
        // LF of a CR LF pair is swallowed.
        crp_d = 1'b0;
      end else begin
        crp_d = 1'b0;
        if (cmt_q) begin
          if (tok_i.cls == CLS_LF) begin
            cmt_d = 1'b0;
          end
        end else if (iq_q) begin
          if (tok_i.cls == CLS_QUOTE) begin
            qp_d = 1'b1;
          end else begin
            do_chr = 1'b1;
          end
        end else begin
          do_unq = 1'b1;
        end
      end

      // Byte in an unquoted position.
      if (do_unq) begin
        if (ars_q && tok_i.cls == CLS_HASH) begin
          cmt_d = 1'b1;
        end else begin
          ars_d = 1'b0;
          case (tok_i.cls) inside
            CLS_QUOTE: iq_d   = 1'b1;
            CLS_COMMA: do_fld = 1'b1;
            CLS_CR, CLS_LF: begin
              do_rec = 1'b1;
              crp_d  = (tok_i.cls == CLS_CR);
            end
            default:   do_chr = 1'b1;
          endcase
        end
      end
    end

    // Data character with the field length limit.
    if (do_chr) begin
      emit = 1'b1;
      if (flen_q >= limits_i.max_field_len) begin
        ev    = EvError;
        code  = ErrLength;
        err_d = 1'b1;
      end else begin
        ev     = EvData;
        data   = chr;
        flen_d = flen_q + 1'b1;
      end
    end

    // Field end with the field count limit.
    if (do_fld) begin
      emit = 1'b1;
      if (fcnt_q >= limits_i.max_fields) begin
        ev    = EvError;
        code  = ErrFields;
        err_d = 1'b1;
      end else begin
        ev     = EvField;
        fcnt_d = fcnt_q + 1'b1;
        flen_d = '0;
      end
    end

    // Record end with the field and row limits.
    if (do_rec) begin
      emit = 1'b1;
      if (fcnt_q >= limits_i.max_fields) begin
        ev    = EvError;
        code  = ErrFields;
        err_d = 1'b1;
        crp_d = 1'b0;
      end else if (rcnt_q >= limits_i.row_limit) begin
        ev    = EvError;
        code  = ErrRows;
        err_d = 1'b1;
        crp_d = 1'b0;
      end else begin
        ev     = EvRecord;
        rcnt_d = rcnt_q + 1'b1;
        fcnt_d = '0;
        flen_d = '0;
        ars_d  = 1'b1;
      end
    end

    if (do_clear) begin
      iq_d   = 1'b0;
      qp_d   = 1'b0;
      crp_d  = 1'b0;
      cmt_d  = 1'b0;
      ars_d  = 1'b1;
      err_d  = 1'b0;
      flen_d = '0;
      fcnt_d = '0;
      rcnt_d = '0;
    end
  end

  // Output slot: refilled by a token with a result, emptied when taken.
  always_comb begin
    if (go) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iq_q  <= 1'b0;
      qp_q  <= 1'b0;
      crp_q <= 1'b0;
      cmt_q <= 1'b0;
      ars_q <= 1'b1;
      err_q <= 1'b0;
      flen_q <= '0;
      fcnt_q <= '0;
      rcnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (go) begin
        iq_q  <= iq_d;
        qp_q  <= qp_d;
        crp_q <= crp_d;
        cmt_q <= cmt_d;
        ars_q <= ars_d;
        err_q <= err_d;
        flen_q <= flen_d;
        fcnt_q <= fcnt_d;
        rcnt_q <= rcnt_d;
      end
    end
  end

  // Result payload; counters are reported as they stood before this token.
  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      out_q.event_res    <= ev;
      out_q.data_byte    <= data;
      out_q.error_code   <= code;
      out_q.field_number <= fcnt_q;
      out_q.row_number   <= rcnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/csv_stream_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted input beat is written into the front-end queue; the back end parses
// it into the registered output slot, which holds the result until it is taken.
// Throughput: one beat per cycle while the output slot is free or being taken.
// A two-entry queue splits classification from parsing, so each side stalls alone.
// Reset: asynchronous and active low; parse state returns to record start and
// the limits return to 4096 characters, 256 fields and 65535 records.
module csv_stream_tokenizer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire cst_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output cst_pkg::out_item_t       out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [cst_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [cst_pkg::CfgW-1:0]    cfg_data_i
);
  import cst_pkg::*;

  limits_t limits_q;
  logic    tok_valid;
  tok_t    tok;
  logic    tok_pop;

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.max_field_len <= MaxFieldLenRst;
      limits_q.max_fields    <= MaxFieldsRst;
      limits_q.row_limit     <= MaxRowsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxFieldLen: limits_q.max_field_len <= cfg_data_i[LenW-1:0];
        CfgMaxFields:   limits_q.max_fields    <= cfg_data_i[FldW-1:0];
        CfgMaxRows:     limits_q.row_limit     <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  cst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .tok_valid_o(tok_valid),
    .tok_o      (tok),
    .tok_pop_i  (tok_pop)
  );

  cst_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limits_i   (limits_q),
    .tok_valid_i(tok_valid),
    .tok_i      (tok),
    .tok_pop_o  (tok_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/csv_token_checker.sv
`timescale 1ns / 1ps

// Watches the byte, result and configuration ports of the tokenizer, predicts the
// token stream from the accepted bytes and compares every result beat in order.
module csv_token_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  cst_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  cst_pkg::out_item_t            out_data_i,
  input  logic                          cfg_we_i,
  input  logic [cst_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cst_pkg::CfgW-1:0]      cfg_data_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o,
  output int unsigned                   error_events_o
);
  import cst_pkg::*;

  localparam int unsigned MaxReports = 10;
  localparam logic [1:0]  NoCode     = 2'b00;

  // Limits as last written.
  logic [LenW-1:0] lim_len;
  logic [FldW-1:0] lim_fields;
  logic [RowW-1:0] lim_rows;

  // Tokenizer state.
  logic            in_quote;
  logic            quote_pend;
  logic            cr_pend;
  logic            in_comment;
  logic            rec_start;
  logic            err_latched;
  logic [LenW-1:0] fld_len;
  logic [FldW-1:0] fld_cnt;
  logic [RowW-1:0] row_cnt;

  out_item_t   expected_tokens[$];
  out_item_t   oldest_token;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned error_cnt;

  assign mismatches_o   = mismatch_cnt;
  assign pending_o      = pending_cnt;
  assign checked_o      = checked_cnt;
  assign error_events_o = error_cnt;

  task automatic emit_token(input logic [1:0] ev, input logic [7:0] ch, input logic [1:0] code);
    out_item_t t;
    t.event_res    = ev;
    t.data_byte    = ch;
    t.error_code   = code;
    t.field_number = fld_cnt;
    t.row_number   = row_cnt;
    expected_tokens = {expected_tokens, t};
  endtask

  task automatic flag_error(input logic [1:0] code);
    err_latched = 1'b1;
    emit_token(EvError, 8'h00, code);
  endtask

  task automatic add_char(input logic [7:0] ch);
    if (fld_len >= lim_len) begin
      flag_error(ErrLength);
    end else begin
      fld_len = fld_len + 1'b1;
      emit_token(EvData, ch, NoCode);
    end
  endtask

  task automatic close_field();
    if (fld_cnt >= lim_fields) begin
      flag_error(ErrFields);
    end else begin
      emit_token(EvField, 8'h00, NoCode);
      fld_cnt = fld_cnt + 1'b1;
      fld_len = '0;
    end
  endtask

  task automatic close_record();
    if (fld_cnt >= lim_fields) begin
      flag_error(ErrFields);
    end else if (row_cnt >= lim_rows) begin
      flag_error(ErrRows);
    end else begin
      emit_token(EvRecord, 8'h00, NoCode);
      row_cnt   = row_cnt + 1'b1;
      fld_cnt   = '0;
      fld_len   = '0;
      rec_start = 1'b1;
    end
  endtask

  task automatic clear_parse();
    in_quote    = 1'b0;
    quote_pend  = 1'b0;
    cr_pend     = 1'b0;
    in_comment  = 1'b0;
    rec_start   = 1'b1;
    err_latched = 1'b0;
    fld_len     = '0;
    fld_cnt     = '0;
    row_cnt     = '0;
  endtask

  // A byte outside any quoted field.
  task automatic unquoted_char(input logic [7:0] b);
    if (rec_start && b == ChHash) begin
      in_comment = 1'b1;
      return;
    end
    rec_start = 1'b0;
    case (b)
      ChQuote: in_quote = 1'b1;
      ChComma: close_field();
      ChCr, ChLf: begin
        close_record();
        if (!err_latched) cr_pend = (b == ChCr);
      end
      default: add_char(b);
    endcase
  endtask

  task automatic doc_char(input logic [7:0] b);
    // A quote after a quote inside a quoted field is a literal quote; anything
    // else closes the field and is taken as an unquoted byte.
    if (quote_pend) begin
      quote_pend = 1'b0;
      if (b == ChQuote) begin
        add_char(ChQuote);
      end else begin
        in_quote = 1'b0;
        unquoted_char(b);
      end
      return;
    end
    // An LF right after a record-ending CR is swallowed.
    if (cr_pend) begin
      cr_pend = 1'b0;
      if (b == ChLf) return;
    end
    if (in_comment) begin
      if (b == ChLf) in_comment = 1'b0;
    end else if (in_quote) begin
      if (b == ChQuote) quote_pend = 1'b1;
      else add_char(b);
    end else begin
      unquoted_char(b);
    end
  endtask

  task automatic finish_document();
    if (quote_pend) begin
      quote_pend = 1'b0;
      in_quote   = 1'b0;
    end
    cr_pend    = 1'b0;
    in_comment = 1'b0;
    if (in_quote) flag_error(ErrQuote);
    else if (!rec_start || fld_len != 0 || fld_cnt != 0) close_record();
    clear_parse();
  endtask

  task automatic tokenize_beat(input in_item_t beat);
    if (beat.kind == KindEod) begin
      if (err_latched) clear_parse();
      else finish_document();
    end else if (!err_latched) begin
      doc_char(beat.byte_in);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_len    = MaxFieldLenRst;
      lim_fields = MaxFieldsRst;
      lim_rows   = MaxRowsRst;
      clear_parse();
      expected_tokens.delete();
      pending_cnt = 0;
    end else begin
      // Compare a result beat with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        checked_cnt++;
        if (out_data_i.event_res == EvError) error_cnt++;
        if (expected_tokens.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("%0t: result with none expected: ev %0d data %h code %0d field %0d row %0d",
                     $time, out_data_i.event_res, out_data_i.data_byte, out_data_i.error_code,
                     out_data_i.field_number, out_data_i.row_number);
        end else begin
          oldest_token = expected_tokens.pop_front();
          if (out_data_i.event_res !== oldest_token.event_res ||
              out_data_i.data_byte !== oldest_token.data_byte ||
              out_data_i.error_code !== oldest_token.error_code ||
              out_data_i.field_number !== oldest_token.field_number ||
              out_data_i.row_number !== oldest_token.row_number) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports) begin
              $display("%0t: mismatch, expected ev %0d data %h code %0d field %0d row %0d",
                       $time, oldest_token.event_res, oldest_token.data_byte,
                       oldest_token.error_code, oldest_token.field_number,
                       oldest_token.row_number);
              $display("%0t:           actual ev %0d data %h code %0d field %0d row %0d",
                       $time, out_data_i.event_res, out_data_i.data_byte,
                       out_data_i.error_code, out_data_i.field_number, out_data_i.row_number);
            end
          end
        end
      end

      // Track limit writes; an index past the list is ignored.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMaxFieldLen: lim_len    = cfg_data_i[LenW-1:0];
          CfgMaxFields:   lim_fields = cfg_data_i[FldW-1:0];
          CfgMaxRows:     lim_rows   = cfg_data_i[RowW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) tokenize_beat(in_data_i);
      pending_cnt = expected_tokens.size();
    end
  end

endmodule

>>> tb/csv_stream_tokenizer_test.sv
`timescale 1ns / 1ps

// Drives CSV documents into the tokenizer under several limit settings and lets the
// checker judge every result beat.
module csv_stream_tokenizer_test;
  import cst_pkg::*;

  localparam logic [8:0]         Eod         = 9'h100;
  localparam logic [CfgIdxW-1:0] CfgUnused   = 2'd3;
  localparam int unsigned        DrainCycles = 8;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  in_item_t           in_data   = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b1;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  bit          idle_on       = 1'b1;
  int unsigned stall_left    = 0;
  int unsigned items_sent    = 0;
  int unsigned docs_sent     = 0;
  int unsigned settings_used = 1;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned error_events;

  // Hand-picked opening sequence: comment lines, quoting corner cases, record
  // terminators and several ways a document can end.
  logic [8:0] directed_beats [26] = '{
    Eod,                                                   // empty document
    {1'b0, ChHash}, {1'b0, ChCr}, {1'b0, ChLf},            // comment with a CR inside
    9'h061, {1'b0, ChHash}, {1'b0, ChComma},               // '#' past record start
    {1'b0, ChQuote}, {1'b0, ChComma}, {1'b0, ChQuote},     // quoted comma
    {1'b0, ChQuote}, {1'b0, ChQuote}, {1'b0, ChCr},        // doubled quote, CR end
    {1'b0, ChLf},                                          // LF after CR swallowed
    9'h000, {1'b0, ChQuote}, 9'h0FF, {1'b0, ChQuote}, Eod, // quote mid-field, flush
    {1'b0, ChComma}, {1'b0, ChLf}, {1'b0, ChQuote}, Eod,   // unterminated quote
    9'h078, {1'b0, ChCr}, Eod                              // CR pending at the end
  };

  csv_stream_tokenizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  csv_token_checker token_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .checked_o      (checked),
    .error_events_o (error_events)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("csv_stream_tokenizer regression: fail");
    $finish;
  end

  // Result side: random stall bursts while idling is enabled.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 7);
      end
    end
  end

  // Mostly random bytes with the steering characters well represented.
  function automatic logic [7:0] stray_byte();
    case ($urandom_range(0, 9))
      0: return ChQuote;
      1: return ChComma;
      2: return ChCr;
      3: return ChLf;
      4: return ChHash;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one beat, possibly after an idle burst, and hold it until accepted.
  task automatic send_item(input logic beat_kind, input logic [7:0] b);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {beat_kind, b};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop offering beats and wait until every predicted result has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic apply_limits(input logic [CfgW-1:0] len, input logic [CfgW-1:0] fields,
                              input logic [CfgW-1:0] rows);
    wait_drained();
    write_reg(CfgMaxFieldLen, len);
    write_reg(CfgMaxFields, fields);
    write_reg(CfgMaxRows, rows);
    settings_used++;
  endtask

  // One field, quoted a third of the time, with doubled quotes inside.
  task automatic send_field(input int unsigned max_len);
    int unsigned n;
    logic [7:0]  c;
    n = $urandom_range(0, max_len);
    if ($urandom_range(0, 2) == 0) begin
      send_item(KindByte, ChQuote);
      repeat (n) begin
        c = ($urandom_range(0, 2) == 0) ? stray_byte() : 8'($urandom);
        send_item(KindByte, c);
        if (c == ChQuote) send_item(KindByte, c);
      end
      send_item(KindByte, ChQuote);
    end else begin
      repeat (n) begin
        if ($urandom_range(0, 29) == 0) begin
          c = stray_byte();
        end else begin
          do c = 8'($urandom);
          while (c == ChQuote || c == ChComma || c == ChCr || c == ChLf);
        end
        send_item(KindByte, c);
      end
    end
  endtask

  // A document of random records and fields, ended by an end-of-document beat.
  task automatic send_document(input int unsigned max_recs, input int unsigned max_fields,
                               input int unsigned max_len);
    int unsigned recs;
    int unsigned nf;
    logic [7:0]  c;
    recs = $urandom_range(0, max_recs);
    for (int r = 0; r < recs; r++) begin
      // Occasional comment line at record start.
      if ($urandom_range(0, 7) == 0) begin
        send_item(KindByte, ChHash);
        repeat ($urandom_range(0, 4)) begin
          c = stray_byte();
          send_item(KindByte, (c == ChLf) ? ChCr : c);
        end
        send_item(KindByte, ChLf);
      end
      nf = $urandom_range(1, max_fields);
      for (int f = 0; f < nf; f++) begin
        if (f != 0) send_item(KindByte, ChComma);
        send_field(max_len);
      end
      // The last record is sometimes left open for the end-of-document flush.
      if (r + 1 < recs || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 2))
          0: send_item(KindByte, ChLf);
          1: send_item(KindByte, ChCr);
          default: begin
            send_item(KindByte, ChCr);
            send_item(KindByte, ChLf);
          end
        endcase
      end
    end
    send_item(KindEod, 8'($urandom));
    docs_sent++;
  endtask

  // Documents until the beat count reaches the goal; one in ten is pure noise.
  task automatic run_random_phase(input int unsigned goal, input int unsigned max_recs,
                                  input int unsigned max_fields, input int unsigned max_len);
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 30)) send_item(KindByte, stray_byte());
        send_item(KindEod, 8'($urandom));
        docs_sent++;
      end else begin
        send_document(max_recs, max_fields, max_len);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset limits.
    foreach (directed_beats[i])
      send_item(directed_beats[i][8],
                directed_beats[i][8] ? 8'($urandom) : directed_beats[i][7:0]);

    // Reset limits, with one full drain in the middle of the stream.
    run_random_phase(items_sent + 200, 4, 5, 6);
    wait_drained();
    run_random_phase(items_sent + 150, 4, 5, 6);

    // Tight limits so every kind of limit error shows up; the unused index is
    // written too and must change nothing.
    wait_drained();
    write_reg(CfgUnused, '1);
    apply_limits(3, 2, 3);
    run_random_phase(items_sent + 300, 5, 4, 5);

    // All limits zero, no idling.
    idle_on = 1'b0;
    apply_limits('0, '0, '0);
    run_random_phase(items_sent + 100, 2, 2, 2);

    // All limits at their maximum.
    idle_on = 1'b1;
    apply_limits('1, '1, '1);
    run_random_phase(items_sent + 250, 4, 6, 8);

    // Mid-range limits, full rate on both sides to the end.
    idle_on = 1'b0;
    apply_limits(8, 5, 4);
    run_random_phase(items_sent + 300, 6, 6, 10);

    wait_drained();
    $display("Covered %0d beats in %0d documents over %0d limit settings.",
             items_sent, docs_sent, settings_used);
    $display("Checked %0d result beats, %0d of them errors; %0d mismatches.",
             checked, error_events, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("csv_stream_tokenizer regression: pass");
    end else begin
      $display("csv_stream_tokenizer regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cst_pkg.sv
rtl/cst_front.sv
rtl/cst_back.sv
rtl/csv_stream_tokenizer.sv
tb/csv_token_checker.sv
tb/csv_stream_tokenizer_test.sv
